FILE: hdl/circle_overlap_pair_detector_macros.svh
// Assertion macros shared by the circle overlap pair detector RTL.
`ifndef CIRCLE_OVERLAP_PAIR_DETECTOR_MACROS_SVH
`define CIRCLE_OVERLAP_PAIR_DETECTOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define COD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define COD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cod_pkg.sv
// Types and constants shared by the circle overlap pair detector modules.
`default_nettype none

package cod_pkg;

  localparam int MAX_BODIES  = 64;
  localparam int COORD_WIDTH = 24;
  localparam int RADIUS_W    = COORD_WIDTH - 1;
  localparam int IDX_W       = $clog2(MAX_BODIES);
  localparam int CNT_W       = $clog2(MAX_BODIES + 1);
  localparam int SQ_W        = 2 * COORD_WIDTH;

  localparam logic [IDX_W-1:0] LAST_STEP  = IDX_W'(MAX_BODIES - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_BODIES);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic [RADIUS_W-1:0]           r;
  } body_t;

  // Status of the compare pipeline toward the sequencer.
  typedef struct packed {
    logic             busy;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } cmp_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_REJECT
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/cod_body_if.sv
// Input channel carrying one body per item.
`default_nettype none

interface cod_body_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    first_of_set;
  logic signed [cod_pkg::COORD_WIDTH-1:0]  pos_x;
  logic signed [cod_pkg::COORD_WIDTH-1:0]  pos_y;
  logic [cod_pkg::RADIUS_W-1:0]            radius;

  modport source (output valid, first_of_set, pos_x, pos_y, radius, input ready);
  modport sink (input valid, first_of_set, pos_x, pos_y, radius, output ready);
endinterface

`default_nettype wire

FILE: hdl/cod_pair_if.sv
// Output channel carrying one overlapping pair per item.
`default_nettype none

interface cod_pair_if;
  logic                       valid;
  logic                       ready;
  logic [cod_pkg::IDX_W-1:0]  earlier_index;
  logic [cod_pkg::IDX_W-1:0]  new_index;
  logic                       last_pair;
  logic                       store_full;

  modport source (output valid, earlier_index, new_index, last_pair, store_full,
                  input ready);
  modport sink (input valid, earlier_index, new_index, last_pair, store_full,
                output ready);
endinterface

`default_nettype wire

FILE: hdl/cod_cell.sv
// One storage cell of the body ring: shifts toward its neighbor or takes a new body.
`default_nettype none

module cod_cell (
  input  logic           clk,
  input  logic           shift_en,
  input  logic           load_en,
  input  cod_pkg::body_t load_body,
  input  cod_pkg::body_t neighbor,
  output cod_pkg::body_t body
);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      body <= load_en ? load_body : neighbor;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cod_cmp.sv
// Overlap test pipeline: differences, then squares, then add and compare.
`default_nettype none

module cod_cmp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      issue_valid,
  input  logic [cod_pkg::IDX_W-1:0] issue_idx,
  input  cod_pkg::body_t            stored,
  input  cod_pkg::body_t            newb,
  output cod_pkg::cmp_res_t         res
);

  localparam int CW = cod_pkg::COORD_WIDTH;

  function automatic logic [CW-1:0] abs_diff(input logic signed [CW-1:0] a,
                                             input logic signed [CW-1:0] b);
    logic signed [CW:0] d;
    logic [CW:0]        m;
    d = {a[CW-1], a} - {b[CW-1], b};
    m = d[CW] ? (~d + 1'b1) : d;
    return m[CW-1:0];
  endfunction

  logic                      st1_valid;
  logic [cod_pkg::IDX_W-1:0] st1_idx;
  logic [CW-1:0]             st1_dx;
  logic [CW-1:0]             st1_dy;
  logic [CW-1:0]             st1_rs;

  logic                      st2_valid;
  logic [cod_pkg::IDX_W-1:0] st2_idx;
  logic [cod_pkg::SQ_W-1:0]  st2_dx2;
  logic [cod_pkg::SQ_W-1:0]  st2_dy2;
  logic [cod_pkg::SQ_W-1:0]  st2_rs2;

  logic [cod_pkg::SQ_W:0]    dist2;

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
      st2_valid <= 1'b0;
    end else if (adv) begin
      st1_valid <= issue_valid;
      st2_valid <= st1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st1_idx <= issue_idx;
      st1_dx  <= abs_diff(stored.x, newb.x);
      st1_dy  <= abs_diff(stored.y, newb.y);
      st1_rs  <= {1'b0, stored.r} + {1'b0, newb.r};
      st2_idx <= st1_idx;
      st2_dx2 <= {{CW{1'b0}}, st1_dx} * {{CW{1'b0}}, st1_dx};
      st2_dy2 <= {{CW{1'b0}}, st1_dy} * {{CW{1'b0}}, st1_dy};
      st2_rs2 <= {{CW{1'b0}}, st1_rs} * {{CW{1'b0}}, st1_rs};
    end
  end

  // The sum keeps its carry, so the compare is exact at every coordinate width.
  assign dist2    = {1'b0, st2_dx2} + {1'b0, st2_dy2};
  assign res.hit  = st2_valid && ({1'b0, st2_rs2} > dist2);
  assign res.idx  = st2_idx;
  assign res.busy = st1_valid || st2_valid;

endmodule

`default_nettype wire

FILE: hdl/circle_overlap_pair_detector.sv
// Circle overlap pair detector: top level with ring of body cells and sequencer.
//
// Usage: bodies arrive on the bodies channel (valid/ready), one body per item,
// each with a center and a radius; first_of_set empties the store first.
// Each stored body that overlaps the new one gives one item on the pairs
// channel, in increasing earlier_index, and the final one has last_pair set.
// A body that overlaps nothing gives no item. With 64 bodies already stored
// the new body is dropped and one item with store_full and last_pair is sent.
// The bodies sit in a ring of 64 cells that turns one full revolution per
// body, presenting body i to the compare pipeline at ring step i and writing
// the new body into place on the way; the next body is taken once the ring is
// back in order and the pipeline is empty. A body passes through the 64 ring
// steps and the drain state before the block is idle again; a dropped body
// passes through the reject state only.
// A pair item is held until the next overlap is found and is then loaded into
// the output register; the final item is loaded there in the drain state once
// the compare pipeline is empty.
// When pairs.ready is low the ring and pipeline stop only when a new overlap
// is found while one pair is held and the output register is full.
// Synchronous reset empties the store and returns the block to idle.
`default_nettype none

module circle_overlap_pair_detector (
  input  logic        clk,
  input  logic        rst,
  cod_body_if.sink    bodies,
  cod_pair_if.source  pairs
);

  `include "circle_overlap_pair_detector_macros.svh"

  cod_pkg::state_t              state;
  cod_pkg::state_t              state_next;
  logic [cod_pkg::IDX_W-1:0]    step;
  logic [cod_pkg::IDX_W-1:0]    new_idx;
  logic [cod_pkg::CNT_W-1:0]    count;
  cod_pkg::body_t               newb;
  logic                         pend_valid;
  logic [cod_pkg::IDX_W-1:0]    pend_idx;

  logic                         out_valid;
  logic [cod_pkg::IDX_W-1:0]    out_earlier;
  logic [cod_pkg::IDX_W-1:0]    out_new;
  logic                         out_last;
  logic                         out_full;

  cod_pkg::body_t               ring [cod_pkg::MAX_BODIES];
  cod_pkg::body_t               in_body;
  cod_pkg::cmp_res_t            cmp_res;

  logic                         accept;
  logic [cod_pkg::CNT_W-1:0]    count_eff;
  logic                         out_free;
  logic                         adv;
  logic                         ring_shift;
  logic                         tail_load;
  logic                         issue_valid;
  logic                         pair_push;
  logic                         final_push;
  logic                         reject_push;
  logic                         out_load;

  assign in_body.x = bodies.pos_x;
  assign in_body.y = bodies.pos_y;
  assign in_body.r = bodies.radius;

  assign count_eff = bodies.first_of_set ? '0 : count;
  assign out_free  = !out_valid || pairs.ready;

  // Ring: cell k takes cell k+1; the last cell takes cell 0 or the new body.
  for (genvar k = 0; k < cod_pkg::MAX_BODIES; k++) begin : g_ring
    cod_cell u_cell (
      .clk       (clk),
      .shift_en  (ring_shift),
      .load_en   (tail_load && (k == cod_pkg::MAX_BODIES - 1)),
      .load_body (newb),
      .neighbor  (ring[(k + 1) % cod_pkg::MAX_BODIES]),
      .body      (ring[k])
    );
  end

  cod_cmp u_cmp (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .issue_valid (issue_valid),
    .issue_idx   (step),
    .stored      (ring[0]),
    .newb        (newb),
    .res         (cmp_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      cod_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (count_eff == cod_pkg::FULL_COUNT) ? cod_pkg::ST_REJECT
                                                          : cod_pkg::ST_RUN;
        end
      end
      cod_pkg::ST_RUN: begin
        if (ring_shift && (step == cod_pkg::LAST_STEP)) begin
          state_next = cod_pkg::ST_DRAIN;
        end
      end
      cod_pkg::ST_DRAIN: begin
        if (!cmp_res.busy && (!pend_valid || out_free)) begin
          state_next = cod_pkg::ST_IDLE;
        end
      end
      cod_pkg::ST_REJECT: begin
        if (out_free) begin
          state_next = cod_pkg::ST_IDLE;
        end
      end
      default: state_next = cod_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    bodies.ready = (state == cod_pkg::ST_IDLE);
    accept       = bodies.valid && bodies.ready;
    // Hold the pipeline only when a new hit must push the held one out and cannot.
    adv          = out_free || !(cmp_res.hit && pend_valid);
    ring_shift   = (state == cod_pkg::ST_RUN) && adv;
    tail_load    = (step == new_idx);
    issue_valid  = (state == cod_pkg::ST_RUN) && (step < new_idx);
    pair_push    = adv && cmp_res.hit && pend_valid;
    final_push   = (state == cod_pkg::ST_DRAIN) && !cmp_res.busy && pend_valid &&
                   out_free;
    reject_push  = (state == cod_pkg::ST_REJECT) && out_free;
    out_load     = pair_push || final_push || reject_push;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cod_pkg::ST_IDLE;
      step       <= '0;
      new_idx    <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        count   <= count_eff;
        new_idx <= count_eff[cod_pkg::IDX_W-1:0];
        step    <= '0;
      end else if (ring_shift) begin
        step <= (step == cod_pkg::LAST_STEP) ? '0 : step + 1'b1;
        if (step == cod_pkg::LAST_STEP) begin
          count <= cod_pkg::CNT_W'(new_idx) + 1'b1;
        end
      end
      if (adv && cmp_res.hit) begin
        pend_valid <= 1'b1;
      end else if (final_push) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pairs.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      newb <= in_body;
    end
    if (adv && cmp_res.hit) begin
      pend_idx <= cmp_res.idx;
    end
    if (out_load) begin
      out_earlier <= reject_push ? '0 : pend_idx;
      out_new     <= reject_push ? '0 : new_idx;
      out_last    <= final_push || reject_push;
      out_full    <= reject_push;
    end
  end

  assign pairs.valid         = out_valid;
  assign pairs.earlier_index = out_earlier;
  assign pairs.new_index     = out_new;
  assign pairs.last_pair     = out_last;
  assign pairs.store_full    = out_full;

  `COD_ASSERT_NOW(a_idle_clean, state == cod_pkg::ST_IDLE, !pend_valid && !cmp_res.busy, "idle with work in flight")
  `COD_ASSERT_NOW(a_no_overwrite, out_load && out_valid, pairs.ready, "output item overwritten")
  `COD_ASSERT_NEXT(a_reject_full, accept && (count_eff == cod_pkg::FULL_COUNT), state == cod_pkg::ST_REJECT && count == cod_pkg::FULL_COUNT, "full store not rejected")

endmodule

`default_nettype wire
